/* sv/wprs_pkg.sv */
// ----------------------------------------------------------------------------
// wprs_pkg
// Shared types and constants for the white pixel region steering block.
// ----------------------------------------------------------------------------
package wprs_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MIN_WIDTH   = 4;
    localparam int COUNT_BITS  = 24;
    localparam int CFG_BITS    = 13;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WID_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int CH_BITS     = 8;
    localparam int TOTAL_BITS  = 24;
    localparam int CODE_BITS   = 2;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET = CFG_BITS'(640);
    localparam logic [CH_BITS-1:0]  WHITE_LEVEL = CH_BITS'(255);

    localparam logic [1:0] BAND_LEFT   = 2'd0;
    localparam logic [1:0] BAND_CENTER = 2'd1;
    localparam logic [1:0] BAND_RIGHT  = 2'd2;

    localparam logic [CODE_BITS-1:0] STEER_STOP    = 2'd0;
    localparam logic [CODE_BITS-1:0] STEER_LEFT    = 2'd1;
    localparam logic [CODE_BITS-1:0] STEER_FORWARD = 2'd2;
    localparam logic [CODE_BITS-1:0] STEER_RIGHT   = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       white;
        logic       last;
        logic [1:0] band;
    } t_stage;

endpackage

/* sv/wprs_pix_if.sv */
// ----------------------------------------------------------------------------
// wprs_pix_if
// Pixel stream channel with valid, ready and the RGB payload.
// ----------------------------------------------------------------------------
interface wprs_pix_if;
    logic                         valid;
    logic                         ready;
    logic [wprs_pkg::CH_BITS-1:0] red;
    logic [wprs_pkg::CH_BITS-1:0] green;
    logic [wprs_pkg::CH_BITS-1:0] blue;
    logic                         frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

/* sv/wprs_res_if.sv */
// ----------------------------------------------------------------------------
// wprs_res_if
// Result channel with valid, ready, the steering code and the band totals.
// ----------------------------------------------------------------------------
interface wprs_res_if;
    logic                            valid;
    logic                            ready;
    logic [wprs_pkg::CODE_BITS-1:0]  steer_code;
    logic [wprs_pkg::TOTAL_BITS-1:0] left_total;
    logic [wprs_pkg::TOTAL_BITS-1:0] center_total;
    logic [wprs_pkg::TOTAL_BITS-1:0] right_total;

    modport source (output valid, steer_code, left_total, center_total, right_total,
                    input ready);
    modport sink   (input valid, steer_code, left_total, center_total, right_total,
                    output ready);
endinterface

/* sv/white_pixel_region_steer_top.sv */
// ----------------------------------------------------------------------------
// white_pixel_region_steer_top
// Counts white pixels in three column bands and steers toward the busiest.
// Throughput: one pixel transfer per cycle while frame results are taken.
// Result path: the last pixel of a frame passes from the input register into
// the result register; that pixel waits in the input register while an earlier
// result is still pending, which stalls the pixel input.
// Reset: synchronous, active low; clears the tallies, column and valid flags,
// and sets the image width to 640.
// ----------------------------------------------------------------------------
module white_pixel_region_steer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wprs_pkg::CFG_BITS-1:0] i_cfg_wdata,
    wprs_pix_if.sink                      i_pix,
    wprs_res_if.source                    o_res
);

    wprs_pkg::t_stage stage;
    logic             take;

    wprs_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (i_pix),
        .i_take      (take),
        .o_stage     (stage)
    );

    wprs_tally u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .o_take  (take),
        .o_res   (o_res)
    );

endmodule

/* sv/wprs_classify.sv */
// ----------------------------------------------------------------------------
// wprs_classify
// Input register stage: holds the width register and column counter, and
// marks each pixel as white and assigns it to a column band.
// ----------------------------------------------------------------------------
module wprs_classify (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wprs_pkg::CFG_BITS-1:0]     i_cfg_wdata,
    wprs_pix_if.sink                          i_pix,
    input  logic                              i_take,
    output wprs_pkg::t_stage                  o_stage
);

    logic [wprs_pkg::CFG_BITS-1:0] r_width;
    logic [wprs_pkg::COL_BITS-1:0] r_col;
    logic [wprs_pkg::COL_BITS-1:0] n_col;
    wprs_pkg::t_stage              r_stage;
    wprs_pkg::t_stage              n_stage;

    logic [wprs_pkg::WID_BITS-1:0] eff_width;
    logic [wprs_pkg::WID_BITS-1:0] quarter;
    logic [wprs_pkg::WID_BITS-1:0] center_end;
    logic [wprs_pkg::WID_BITS-1:0] col_ext;
    logic [wprs_pkg::WID_BITS-1:0] col_inc;
    logic                          accept;
    logic                          white;

    always_comb begin
        if (r_width < wprs_pkg::CFG_BITS'(wprs_pkg::MIN_WIDTH)) begin
            eff_width = wprs_pkg::WID_BITS'(wprs_pkg::MIN_WIDTH);
        end else if (r_width > wprs_pkg::CFG_BITS'(wprs_pkg::MAX_WIDTH)) begin
            eff_width = wprs_pkg::WID_BITS'(wprs_pkg::MAX_WIDTH);
        end else begin
            eff_width = wprs_pkg::WID_BITS'(r_width);
        end
    end

    assign quarter    = eff_width >> 2;
    assign center_end = (eff_width >> 1) + (eff_width >> 2);
    assign col_ext    = wprs_pkg::WID_BITS'(r_col);
    assign col_inc    = col_ext + wprs_pkg::WID_BITS'(1);

    assign white = (i_pix.red == wprs_pkg::WHITE_LEVEL) &&
                   (i_pix.green == wprs_pkg::WHITE_LEVEL) &&
                   (i_pix.blue == wprs_pkg::WHITE_LEVEL);

    assign i_pix.ready = i_rst_n && (!r_stage.valid || i_take);
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        n_col   = r_col;
        n_stage = r_stage;
        if (i_take) begin
            n_stage.valid = 1'b0;
        end
        if (accept) begin
            n_stage.valid = 1'b1;
            n_stage.white = white;
            n_stage.last  = i_pix.frame_end;
            if (col_ext < quarter) begin
                n_stage.band = wprs_pkg::BAND_LEFT;
            end else if (col_ext < center_end) begin
                n_stage.band = wprs_pkg::BAND_CENTER;
            end else begin
                n_stage.band = wprs_pkg::BAND_RIGHT;
            end
            if (i_pix.frame_end || (col_inc >= eff_width)) begin
                n_col = '0;
            end else begin
                n_col = col_inc[wprs_pkg::COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= wprs_pkg::WIDTH_RESET;
            r_col   <= '0;
            r_stage <= '0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            r_col   <= n_col;
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

/* sv/wprs_tally.sv */
// ----------------------------------------------------------------------------
// wprs_tally
// Result stage: updates the saturating band tallies and, on the last pixel
// of a frame, loads the result register with the totals and steering code.
// ----------------------------------------------------------------------------
module wprs_tally (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wprs_pkg::t_stage i_stage,
    output logic             o_take,
    wprs_res_if.source       o_res
);

    localparam logic [wprs_pkg::COUNT_BITS-1:0] LIMIT = '1;

    logic [wprs_pkg::COUNT_BITS-1:0] r_left;
    logic [wprs_pkg::COUNT_BITS-1:0] r_center;
    logic [wprs_pkg::COUNT_BITS-1:0] r_right;
    logic [wprs_pkg::COUNT_BITS-1:0] n_left;
    logic [wprs_pkg::COUNT_BITS-1:0] n_center;
    logic [wprs_pkg::COUNT_BITS-1:0] n_right;
    logic                            r_valid;
    logic [wprs_pkg::CODE_BITS-1:0]  r_code;
    logic [wprs_pkg::TOTAL_BITS-1:0] r_left_out;
    logic [wprs_pkg::TOTAL_BITS-1:0] r_center_out;
    logic [wprs_pkg::TOTAL_BITS-1:0] r_right_out;
    logic [wprs_pkg::CODE_BITS-1:0]  n_code;
    logic                            emit;

    assign o_take = i_stage.valid && (!i_stage.last || !r_valid || o_res.ready);
    assign emit   = o_take && i_stage.last;

    always_comb begin
        n_left   = r_left;
        n_center = r_center;
        n_right  = r_right;
        if (i_stage.white) begin
            case (i_stage.band)
                wprs_pkg::BAND_LEFT: begin
                    if (r_left != LIMIT) n_left = r_left + 1'b1;
                end
                wprs_pkg::BAND_CENTER: begin
                    if (r_center != LIMIT) n_center = r_center + 1'b1;
                end
                default: begin
                    if (r_right != LIMIT) n_right = r_right + 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        if ((n_left == '0) && (n_center == '0) && (n_right == '0)) begin
            n_code = wprs_pkg::STEER_STOP;
        end else if ((n_left >= n_center) && (n_left >= n_right)) begin
            n_code = wprs_pkg::STEER_LEFT;
        end else if (n_center >= n_right) begin
            n_code = wprs_pkg::STEER_FORWARD;
        end else begin
            n_code = wprs_pkg::STEER_RIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_center <= '0;
            r_right  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (emit) begin
                r_left   <= '0;
                r_center <= '0;
                r_right  <= '0;
                r_valid  <= 1'b1;
            end else begin
                if (o_take) begin
                    r_left   <= n_left;
                    r_center <= n_center;
                    r_right  <= n_right;
                end
                if (o_res.ready) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_code       <= n_code;
            r_left_out   <= wprs_pkg::TOTAL_BITS'(n_left);
            r_center_out <= wprs_pkg::TOTAL_BITS'(n_center);
            r_right_out  <= wprs_pkg::TOTAL_BITS'(n_right);
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.steer_code   = r_code;
    assign o_res.left_total   = r_left_out;
    assign o_res.center_total = r_center_out;
    assign o_res.right_total  = r_right_out;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the white pixel region steering block. A driver
// sends pixel transfers from a backlog, a scoreboard model tracks the column
// and band tallies, and a monitor checks each frame report against it.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [wprs_pkg::CH_BITS-1:0] red;
        logic [wprs_pkg::CH_BITS-1:0] green;
        logic [wprs_pkg::CH_BITS-1:0] blue;
        logic                         frame_end;
    } t_pixel;

    typedef struct packed {
        logic [wprs_pkg::CODE_BITS-1:0]  steer_code;
        logic [wprs_pkg::TOTAL_BITS-1:0] left_total;
        logic [wprs_pkg::TOTAL_BITS-1:0] center_total;
        logic [wprs_pkg::TOTAL_BITS-1:0] right_total;
    } t_report;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [wprs_pkg::CFG_BITS-1:0] cfg_wdata;

    wprs_pix_if pix_bus();
    wprs_res_if res_bus();

    white_pixel_region_steer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_pix       (pix_bus),
        .o_res       (res_bus)
    );

    always #6 clk = ~clk;

    logic [wprs_pkg::CFG_BITS-1:0]   width_reg;
    logic [wprs_pkg::COL_BITS-1:0]   column;
    logic [wprs_pkg::COUNT_BITS-1:0] left_tally;
    logic [wprs_pkg::COUNT_BITS-1:0] center_tally;
    logic [wprs_pkg::COUNT_BITS-1:0] right_tally;

    t_pixel  pixel_backlog[$];
    t_pixel  pixel_on_bus;
    t_report frame_reports[$];
    int      fault_count = 0;
    bit      steady = 1'b0;

    function automatic logic [wprs_pkg::CFG_BITS-1:0] clamp_width(
        input logic [wprs_pkg::CFG_BITS-1:0] v);
        if (v < wprs_pkg::MIN_WIDTH) begin
            return wprs_pkg::CFG_BITS'(wprs_pkg::MIN_WIDTH);
        end
        if (v > wprs_pkg::MAX_WIDTH) begin
            return wprs_pkg::CFG_BITS'(wprs_pkg::MAX_WIDTH);
        end
        return v;
    endfunction

    function automatic logic [wprs_pkg::COUNT_BITS-1:0] bump_tally(
        input logic [wprs_pkg::COUNT_BITS-1:0] t);
        return (t != '1) ? t + 1'b1 : t;
    endfunction

    task automatic tally_pixel(input t_pixel px);
        logic [wprs_pkg::CFG_BITS-1:0] w;
        logic [wprs_pkg::CFG_BITS-1:0] quarter;
        logic [wprs_pkg::CFG_BITS-1:0] center_end;
        logic [wprs_pkg::CFG_BITS-1:0] col_next;
        logic                          white;
        t_report                       rep;
        w          = clamp_width(width_reg);
        quarter    = w >> 2;
        center_end = (w >> 1) + (w >> 2);
        white = (px.red == wprs_pkg::WHITE_LEVEL) && (px.green == wprs_pkg::WHITE_LEVEL) &&
                (px.blue == wprs_pkg::WHITE_LEVEL);
        if (white) begin
            if (wprs_pkg::CFG_BITS'(column) < quarter) begin
                left_tally = bump_tally(left_tally);
            end else if (wprs_pkg::CFG_BITS'(column) < center_end) begin
                center_tally = bump_tally(center_tally);
            end else begin
                right_tally = bump_tally(right_tally);
            end
        end
        col_next = wprs_pkg::CFG_BITS'(column) + 1'b1;
        column   = (col_next >= w) ? '0 : col_next[wprs_pkg::COL_BITS-1:0];
        if (px.frame_end) begin
            if (left_tally == 0 && center_tally == 0 && right_tally == 0) begin
                rep.steer_code = wprs_pkg::STEER_STOP;
            end else if (left_tally >= center_tally && left_tally >= right_tally) begin
                rep.steer_code = wprs_pkg::STEER_LEFT;
            end else if (center_tally >= right_tally) begin
                rep.steer_code = wprs_pkg::STEER_FORWARD;
            end else begin
                rep.steer_code = wprs_pkg::STEER_RIGHT;
            end
            rep.left_total   = left_tally[wprs_pkg::TOTAL_BITS-1:0];
            rep.center_total = center_tally[wprs_pkg::TOTAL_BITS-1:0];
            rep.right_total  = right_tally[wprs_pkg::TOTAL_BITS-1:0];
            frame_reports.push_back(rep);
            left_tally   = '0;
            center_tally = '0;
            right_tally  = '0;
            column       = '0;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            pix_bus.valid <= 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                tally_pixel(pixel_on_bus);
            end
            if (!pix_bus.valid || pix_bus.ready) begin
                if (pixel_backlog.size() > 0 && (steady || $urandom_range(99) >= 30)) begin
                    pixel_on_bus = pixel_backlog.pop_front();
                    pix_bus.valid     <= 1'b1;
                    pix_bus.red       <= pixel_on_bus.red;
                    pix_bus.green     <= pixel_on_bus.green;
                    pix_bus.blue      <= pixel_on_bus.blue;
                    pix_bus.frame_end <= pixel_on_bus.frame_end;
                end else begin
                    pix_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_report want;
        t_report seen;
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                seen.steer_code   = res_bus.steer_code;
                seen.left_total   = res_bus.left_total;
                seen.center_total = res_bus.center_total;
                seen.right_total  = res_bus.right_total;
                if (frame_reports.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected report: code %0d totals %0d %0d %0d",
                                 seen.steer_code, seen.left_total, seen.center_total,
                                 seen.right_total);
                    end
                end else begin
                    want = frame_reports.pop_front();
                    if (seen.steer_code !== want.steer_code ||
                        seen.left_total !== want.left_total ||
                        seen.center_total !== want.center_total ||
                        seen.right_total !== want.right_total) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display({"report mismatch: expected code %0d totals %0d %0d %0d,",
                                      " got code %0d totals %0d %0d %0d"},
                                     want.steer_code, want.left_total, want.center_total,
                                     want.right_total, seen.steer_code, seen.left_total,
                                     seen.center_total, seen.right_total);
                        end
                    end
                end
            end
            res_bus.ready <= steady || ($urandom_range(99) >= 30);
        end
    end

    task automatic push_px(input logic [wprs_pkg::CH_BITS-1:0] r,
                           input logic [wprs_pkg::CH_BITS-1:0] g,
                           input logic [wprs_pkg::CH_BITS-1:0] b, input logic fe);
        t_pixel px;
        px.red       = r;
        px.green     = g;
        px.blue      = b;
        px.frame_end = fe;
        pixel_backlog.push_back(px);
    endtask

    task automatic queue_frames(input int count);
        int     w;
        int     span;
        int     remaining;
        int     pick;
        t_pixel px;
        w         = clamp_width(width_reg);
        span      = (3 * w < 60) ? 3 * w : 60;
        remaining = 0;
        for (int k = 0; k < count; k++) begin
            if (remaining == 0) begin
                remaining = $urandom_range(span, 1);
            end
            px.red   = wprs_pkg::CH_BITS'($urandom);
            px.green = wprs_pkg::CH_BITS'($urandom);
            px.blue  = wprs_pkg::CH_BITS'($urandom);
            pick = $urandom_range(99);
            if (pick < 55) begin
                px.red   = wprs_pkg::WHITE_LEVEL;
                px.green = wprs_pkg::WHITE_LEVEL;
                px.blue  = wprs_pkg::WHITE_LEVEL;
                if (pick >= 40) begin
                    case ($urandom_range(2))
                        0: px.red   = wprs_pkg::CH_BITS'($urandom);
                        1: px.green = wprs_pkg::CH_BITS'($urandom);
                        default: px.blue = wprs_pkg::CH_BITS'($urandom);
                    endcase
                end
            end
            remaining--;
            px.frame_end = (remaining == 0);
            pixel_backlog.push_back(px);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pixel_backlog.size() != 0 || pix_bus.valid || frame_reports.size() != 0) begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [wprs_pkg::CFG_BITS-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_reg = v;
    endtask

    localparam int PHASE_WIDTHS [15] = '{3, 0, 8191, 6, 4096, 5, 100, 7, 4097, 9, 37, 4,
                                         13, 640, 12};

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        pix_bus.valid     = 1'b0;
        pix_bus.red       = '0;
        pix_bus.green     = '0;
        pix_bus.blue      = '0;
        pix_bus.frame_end = 1'b0;
        res_bus.ready     = 1'b0;
        width_reg         = wprs_pkg::WIDTH_RESET;
        column            = '0;
        left_tally        = '0;
        center_tally      = '0;
        right_tally       = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        push_px(8'd255, 8'd255, 8'd255, 1'b1);
        push_px(8'd0, 8'd0, 8'd0, 1'b1);
        push_px(8'd255, 8'd255, 8'd254, 1'b1);
        wait_idle();

        write_width(wprs_pkg::CFG_BITS'(4));
        push_px(8'd0, 8'd0, 8'd0, 1'b0);
        push_px(8'd255, 8'd255, 8'd255, 1'b0);
        push_px(8'd0, 8'd0, 8'd0, 1'b0);
        push_px(8'd255, 8'd255, 8'd255, 1'b1);
        push_px(8'd0, 8'd255, 8'd255, 1'b0);
        push_px(8'd255, 8'd0, 8'd255, 1'b0);
        push_px(8'd255, 8'd255, 8'd0, 1'b0);
        push_px(8'd255, 8'd255, 8'd255, 1'b1);
        push_px(8'd255, 8'd255, 8'd255, 1'b0);
        push_px(8'd128, 8'd64, 8'd1, 1'b0);
        push_px(8'd127, 8'd191, 8'd254, 1'b0);
        push_px(8'd255, 8'd255, 8'd255, 1'b1);
        push_px(8'd0, 8'd0, 8'd0, 1'b0);
        push_px(8'd255, 8'd255, 8'd255, 1'b1);
        push_px(8'd255, 8'd255, 8'd255, 1'b1);
        for (int k = 0; k < 6; k++) begin
            push_px(8'd255, 8'd255, 8'd255, k == 5);
        end
        wait_idle();

        foreach (PHASE_WIDTHS[p]) begin
            write_width(wprs_pkg::CFG_BITS'(PHASE_WIDTHS[p]));
            steady = (p == 6);
            queue_frames(58);
            wait_idle();
        end
        steady = 1'b0;

        repeat (8) @(posedge clk);
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
